// ===== hw/rtl/lpg_pkg.sv =====
// Shared constants, pattern and action codes for the LED pattern generator.
// Also holds the elaboration-time builder for the breathing factor table.
// No dependencies.
package lpg_pkg;

   // field widths
   localparam int ACTION_W   = 2;
   localparam int ELAPSED_W  = 16;
   localparam int PATTERN_W  = 3;
   localparam int COLOR_W    = 24;
   localparam int CHAN_W     = 8;
   localparam int PHASE_W    = 32;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // req_tdata layout
   localparam int ELAPSED_LSB = 0;
   localparam int PATTERN_LSB = ELAPSED_LSB + ELAPSED_W;
   localparam int COLOR_LSB   = PATTERN_LSB + PATTERN_W;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STOP  = 2'd2;

   // pattern codes
   localparam logic [PATTERN_W-1:0] PAT_OFF          = 3'd0;
   localparam logic [PATTERN_W-1:0] PAT_SOLID        = 3'd1;
   localparam logic [PATTERN_W-1:0] PAT_PULSE_SLOW   = 3'd2;
   localparam logic [PATTERN_W-1:0] PAT_PULSE_FAST   = 3'd3;
   localparam logic [PATTERN_W-1:0] PAT_BLINK_ONCE   = 3'd4;
   localparam logic [PATTERN_W-1:0] PAT_BLINK_DOUBLE = 3'd5;
   localparam logic [PATTERN_W-1:0] PAT_BLINK_TRIPLE = 3'd6;
   localparam logic [PATTERN_W-1:0] PAT_BLINK_SLOW   = 3'd7;

   // timeline points, ms
   localparam logic [PHASE_W-1:0] ONCE_END     = 32'd200;
   localparam logic [PHASE_W-1:0] DOUBLE_END   = 32'd400;
   localparam logic [PHASE_W-1:0] DOUBLE_ON    = 32'd100;
   localparam logic [PHASE_W-1:0] DOUBLE_ON2_A = 32'd200;
   localparam logic [PHASE_W-1:0] DOUBLE_ON2_B = 32'd300;
   localparam logic [PHASE_W-1:0] TRIPLE_END   = 32'd480;
   localparam logic [PHASE_W-1:0] TRIPLE_ON    = 32'd80;
   localparam logic [PHASE_W-1:0] TRIPLE_ON2_A = 32'd160;
   localparam logic [PHASE_W-1:0] TRIPLE_ON2_B = 32'd240;
   localparam logic [PHASE_W-1:0] TRIPLE_ON3_A = 32'd320;
   localparam logic [PHASE_W-1:0] TRIPLE_ON3_B = 32'd400;

   // phase is also tracked modulo the flash period; 1000 and 250 divide it
   localparam int FLASH_PERIOD = 2000;
   localparam int FLASH_ON     = 100;
   localparam int SLOW_PERIOD  = 1000;
   localparam int FAST_PERIOD  = 250;
   localparam int REM_W        = 11;
   localparam int REM_SUM_W    = 13;
   localparam int FAST_REM_W   = 8;
   localparam longint unsigned PHASE_MOD = 64'd1 << PHASE_W;
   // added to the remainder when the phase wraps past 2^32
   localparam int WRAP_ADJ = FLASH_PERIOD - int'(PHASE_MOD % FLASH_PERIOD);
   // floor reciprocal of the flash period for elapsed_ms reduction
   localparam int RECIP_SHIFT = 26;
   localparam int RECIP_MUL   = (1 << RECIP_SHIFT) / FLASH_PERIOD;
   localparam int QUOT_W      = 6;
   localparam int REM_EST_W   = 12;

   // breathing table
   localparam int COSINE_TABLE_DEPTH = 1000;
   localparam int ROM_ADDR_W         = $clog2(COSINE_TABLE_DEPTH);
   localparam int FAST_STEP_SHIFT    = 2;
   localparam int COS_TERMS          = 10;
   localparam logic [63:0] TWO_PI_Q48 = 64'h0006_487E_D511_0B46;
   localparam logic [63:0] ONE_Q31    = 64'h0000_0000_8000_0000;

   typedef logic [CHAN_W-1:0] breath_rom_type [COSINE_TABLE_DEPTH];

   // cos(2*pi*j/1000) in Q31 for 0 <= j <= 250, truncated Taylor series
   function automatic logic [63:0] cos_q31(input logic [63:0] j);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      int unsigned        n;
      x    = ((j * TWO_PI_Q48) / 64'(COSINE_TABLE_DEPTH)) >> 17;
      x2   = (x * x) >> 31;
      term = ONE_Q31;
      acc  = signed'(ONE_Q31);
      for (n = 1; n <= COS_TERMS; n++) begin
         term = ((term * x2) >> 31) / 64'((2 * n - 1) * (2 * n));
         if ((n & 1) != 0) begin
            acc = acc - signed'(term);
         end else begin
            acc = acc + signed'(term);
         end
      end
      if (acc < 0) begin
         acc = '0;
      end
      return unsigned'(acc);
   endfunction

   // floor(127.5 * (1 - cos(2*pi*k/1000)))
   function automatic logic [CHAN_W-1:0] breath_factor(input logic [63:0] k);
      logic [63:0] kf;
      logic [63:0] c;
      logic [63:0] om;
      logic [63:0] f;
      kf = (k > 64'(COSINE_TABLE_DEPTH / 2)) ? 64'(COSINE_TABLE_DEPTH) - k : k;
      if (kf > 64'(COSINE_TABLE_DEPTH / 4)) begin
         c  = cos_q31(64'(COSINE_TABLE_DEPTH / 2) - kf);
         om = ONE_Q31 + c;
      end else begin
         c  = cos_q31(kf);
         om = (c > ONE_Q31) ? 64'd0 : ONE_Q31 - c;
      end
      f = (om * 64'd255) >> 32;
      return (f > 64'd255) ? 8'hFF : f[CHAN_W-1:0];
   endfunction

   function automatic breath_rom_type build_breath_rom();
      breath_rom_type rom;
      for (int k = 0; k < COSINE_TABLE_DEPTH; k++) begin
         rom[k] = breath_factor(64'(k));
      end
      return rom;
   endfunction

endpackage

// ===== hw/rtl/led_pattern_generator.sv =====
// Single-LED pattern generator top level.
// Depends on lpg_pkg (codes, timeline constants, breathing table builder).
//
// Takes one word per clock on req_ (tuser = action: tick, start, stop).
// Start stores pattern and color and clears the phase, giving no output;
// stop turns the LED black; each tick advances the phase by elapsed_ms and
// returns one color on rsp_, with tlast set on the tick that ends a blink
// sequence. Throughput is one word per cycle unless rsp_tready stalls;
// words pass the pattern state, the lookup stage (registered read of the
// 1000-entry breathing table) and the output register. The phase is also
// kept modulo 2000 ms so the breathing and flash positions need no divider.
module led_pattern_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] elapsed_ms, [18:16] pattern_code, [42:19] color_in, rest zero
   input  logic [lpg_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] action
   input  logic [lpg_pkg::ACTION_W-1:0]    req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [23:0] pixel_color
   output logic [lpg_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // pattern_ended
   output logic                            rsp_tlast
);
   import lpg_pkg::*;

   typedef enum logic [1:0] {
      PIX_BLACK,
      PIX_BASE,
      PIX_SCALED
   } pix_mode_type;

   localparam breath_rom_type BreathRom = build_breath_rom();

   // ---------------- pattern state ----------------
   logic [PATTERN_W-1:0] pattern_ff, pattern_in;
   logic [COLOR_W-1:0]   color_ff, color_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic                 pend_ff, pend_in;
   logic                 pend_stop_ff, pend_stop_in;

   // ---------------- lookup stage ----------------
   logic                 s2_valid_ff, s2_valid_in;
   pix_mode_type         s2_mode_ff, s2_mode_in;
   logic                 s2_ended_ff, s2_ended_in;
   logic [COLOR_W-1:0]   s2_color_ff, s2_color_in;
   logic [CHAN_W-1:0]    factor_ff;

   // ---------------- output register ----------------
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]   rsp_color_ff, rsp_color_in;
   logic                 rsp_ended_ff, rsp_ended_in;

   logic out_en, s2_en, s1_en, accept;

   assign out_en     = !rsp_valid_ff || rsp_tready;
   assign s2_en      = !s2_valid_ff || out_en;
   assign s1_en      = !pend_ff || s2_en;
   assign req_tready = s1_en;
   assign accept     = req_tvalid && s1_en;

   // ---------------- input decode and phase update ----------------
   logic [ELAPSED_W-1:0] elapsed;
   logic [PATTERN_W-1:0] code;
   logic [COLOR_W-1:0]   color_word;
   logic [PHASE_W:0]     phase_sum;
   logic [PHASE_W-1:0]   recip_prod;
   logic [QUOT_W-1:0]    quot;
   logic [ELAPSED_W-1:0] quot_x;
   logic [REM_EST_W-1:0] rem_est;
   logic [REM_W-1:0]     elapsed_mod;
   logic [REM_SUM_W-1:0] rem_sum;
   logic [REM_W-1:0]     rem_next;
   logic                 blink_done;
   logic [PATTERN_W-1:0] eff_pattern;

   assign elapsed    = req_tdata[ELAPSED_LSB +: ELAPSED_W];
   assign code       = req_tdata[PATTERN_LSB +: PATTERN_W];
   assign color_word = req_tdata[COLOR_LSB +: COLOR_W];

   always_comb begin
      phase_sum  = {1'b0, phase_ff} + (PHASE_W + 1)'(elapsed);
      // elapsed mod 2000: estimate quotient low by at most one, then fix up
      recip_prod = PHASE_W'(elapsed) * PHASE_W'(RECIP_MUL);
      quot       = recip_prod[RECIP_SHIFT +: QUOT_W];
      quot_x     = ELAPSED_W'(quot) * ELAPSED_W'(FLASH_PERIOD);
      rem_est    = REM_EST_W'(elapsed - quot_x);
      elapsed_mod = (rem_est >= REM_EST_W'(FLASH_PERIOD)) ?
                    REM_W'(rem_est - REM_EST_W'(FLASH_PERIOD)) : REM_W'(rem_est);
      rem_sum = REM_SUM_W'(rem_ff) + REM_SUM_W'(elapsed_mod) +
                (phase_sum[PHASE_W] ? REM_SUM_W'(WRAP_ADJ) : REM_SUM_W'(0));
      if (rem_sum >= REM_SUM_W'(2 * FLASH_PERIOD)) begin
         rem_next = REM_W'(rem_sum - REM_SUM_W'(2 * FLASH_PERIOD));
      end else if (rem_sum >= REM_SUM_W'(FLASH_PERIOD)) begin
         rem_next = REM_W'(rem_sum - REM_SUM_W'(FLASH_PERIOD));
      end else begin
         rem_next = REM_W'(rem_sum);
      end

      // a blink that reached its end on the previous tick is now off
      case (pattern_ff)
         PAT_BLINK_ONCE:   blink_done = (phase_ff >= ONCE_END);
         PAT_BLINK_DOUBLE: blink_done = (phase_ff >= DOUBLE_END);
         PAT_BLINK_TRIPLE: blink_done = (phase_ff >= TRIPLE_END);
         default:          blink_done = 1'b0;
      endcase
      eff_pattern = blink_done ? PAT_OFF : pattern_ff;
   end

   always_comb begin
      pattern_in   = pattern_ff;
      color_in     = color_ff;
      phase_in     = phase_ff;
      rem_in       = rem_ff;
      pend_in      = pend_ff;
      pend_stop_in = pend_stop_ff;
      if (s1_en) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         unique case (req_tuser)
            ACT_START: begin
               pattern_in = code;
               color_in   = color_word;
               phase_in   = '0;
               rem_in     = '0;
            end
            ACT_STOP: begin
               pattern_in   = PAT_OFF;
               pend_in      = 1'b1;
               pend_stop_in = 1'b1;
            end
            ACT_TICK: begin
               pattern_in   = eff_pattern;
               phase_in     = phase_sum[PHASE_W-1:0];
               rem_in       = rem_next;
               pend_in      = 1'b1;
               pend_stop_in = 1'b0;
            end
            default: begin
               // unused action code: ignored
            end
         endcase
      end
   end

   // ---------------- color decision from the updated state ----------------
   logic [REM_W-1:0]      rem_slow;
   logic [FAST_REM_W-1:0] rem_fast;
   logic [ROM_ADDR_W-1:0] rom_addr;

   always_comb begin
      rem_slow = (rem_ff >= REM_W'(SLOW_PERIOD)) ? rem_ff - REM_W'(SLOW_PERIOD) : rem_ff;
      if (rem_slow >= REM_W'(3 * FAST_PERIOD)) begin
         rem_fast = FAST_REM_W'(rem_slow - REM_W'(3 * FAST_PERIOD));
      end else if (rem_slow >= REM_W'(2 * FAST_PERIOD)) begin
         rem_fast = FAST_REM_W'(rem_slow - REM_W'(2 * FAST_PERIOD));
      end else if (rem_slow >= REM_W'(FAST_PERIOD)) begin
         rem_fast = FAST_REM_W'(rem_slow - REM_W'(FAST_PERIOD));
      end else begin
         rem_fast = FAST_REM_W'(rem_slow);
      end
      // fast pulse: k = (t mod 250) * 4
      rom_addr = (pattern_ff == PAT_PULSE_SLOW) ? ROM_ADDR_W'(rem_slow) :
                 ROM_ADDR_W'({rem_fast, FAST_STEP_SHIFT'(0)});
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_mode_in  = s2_mode_ff;
      s2_ended_in = s2_ended_ff;
      s2_color_in = s2_color_ff;
      if (s2_en) begin
         s2_valid_in = pend_ff;
         s2_color_in = color_ff;
         s2_mode_in  = PIX_BLACK;
         s2_ended_in = 1'b0;
         if (!pend_stop_ff) begin
            case (pattern_ff) inside
               PAT_SOLID: s2_mode_in = PIX_BASE;
               PAT_PULSE_SLOW, PAT_PULSE_FAST: s2_mode_in = PIX_SCALED;
               PAT_BLINK_ONCE: begin
                  if (phase_ff < ONCE_END) begin
                     s2_mode_in = PIX_BASE;
                  end else begin
                     s2_ended_in = 1'b1;
                  end
               end
               PAT_BLINK_DOUBLE: begin
                  if (phase_ff < DOUBLE_END) begin
                     if (phase_ff < DOUBLE_ON ||
                         (phase_ff >= DOUBLE_ON2_A && phase_ff < DOUBLE_ON2_B)) begin
                        s2_mode_in = PIX_BASE;
                     end
                  end else begin
                     s2_ended_in = 1'b1;
                  end
               end
               PAT_BLINK_TRIPLE: begin
                  if (phase_ff < TRIPLE_END) begin
                     if (phase_ff < TRIPLE_ON ||
                         (phase_ff >= TRIPLE_ON2_A && phase_ff < TRIPLE_ON2_B) ||
                         (phase_ff >= TRIPLE_ON3_A && phase_ff < TRIPLE_ON3_B)) begin
                        s2_mode_in = PIX_BASE;
                     end
                  end else begin
                     s2_ended_in = 1'b1;
                  end
               end
               PAT_BLINK_SLOW: begin
                  if (rem_ff < REM_W'(FLASH_ON)) begin
                     s2_mode_in = PIX_BASE;
                  end
               end
               default: s2_mode_in = PIX_BLACK;
            endcase
         end
      end
   end

   // ---------------- channel scaling into the output register ----------------
   logic [2*CHAN_W-1:0] scaled_r, scaled_g, scaled_b;

   always_comb begin
      scaled_r = s2_color_ff[2*CHAN_W +: CHAN_W] * factor_ff;
      scaled_g = s2_color_ff[CHAN_W +: CHAN_W] * factor_ff;
      scaled_b = s2_color_ff[0 +: CHAN_W] * factor_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_color_in = rsp_color_ff;
      rsp_ended_in = rsp_ended_ff;
      if (out_en) begin
         rsp_valid_in = s2_valid_ff;
         rsp_ended_in = s2_ended_ff;
         case (s2_mode_ff)
            PIX_BASE:   rsp_color_in = s2_color_ff;
            PIX_SCALED: rsp_color_in = {scaled_r[CHAN_W +: CHAN_W],
                                        scaled_g[CHAN_W +: CHAN_W],
                                        scaled_b[CHAN_W +: CHAN_W]};
            default:    rsp_color_in = '0;
         endcase
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff   <= PAT_OFF;
         color_ff     <= '0;
         phase_ff     <= '0;
         rem_ff       <= '0;
         pend_ff      <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pattern_ff   <= pattern_in;
         color_ff     <= color_in;
         phase_ff     <= phase_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_stop_ff <= pend_stop_in;
      s2_mode_ff   <= s2_mode_in;
      s2_ended_ff  <= s2_ended_in;
      s2_color_ff  <= s2_color_in;
      rsp_color_ff <= rsp_color_in;
      rsp_ended_ff <= rsp_ended_in;
   end

   // breathing table, registered read
   always_ff @(posedge clock) begin
      if (s2_en) begin
         factor_ff <= BreathRom[rom_addr];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_color_ff;
   assign rsp_tlast  = rsp_ended_ff;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for led_pattern_generator: directed words, a full-rate breathing run,
// then random pattern sequences with idle gaps on requests and backpressure on results.
// Depends on lpg_pkg and the led_pattern_generator RTL.
module testbench;
   import lpg_pkg::*;

   localparam int CLOCK_HALF       = 5;
   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int FULL_RATE_ITEMS  = 40;
   localparam int RANDOM_ITEMS     = 550;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES      = 10;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // 2*pi in Q48, 1.0 in Q31
   localparam logic [63:0] TAU_Q48 = 64'h0006_487E_D511_0B46;
   localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;

   typedef struct packed {
      logic [COLOR_W-1:0] color;
      logic               ended;
   } pixel_word_type;

   class led_scoreboard_type;
      logic [PATTERN_W-1:0] pattern;
      logic [COLOR_W-1:0]   base_color;
      logic [PHASE_W-1:0]   phase_ms;
      pixel_word_type       expected_pixels[$];
      int                   errors;

      function new();
         pattern       = PAT_OFF;
         base_color    = '0;
         phase_ms      = '0;
         errors        = 0;
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      // cos(2*pi*step/1000) in Q31, step in 0..250, 10-term series
      function logic [63:0] cosine_q31(int unsigned step);
         logic [63:0] angle;
         logic [63:0] angle_sq;
         logic [63:0] term;
         longint      sum;
         angle    = (64'(step) * TAU_Q48 / 64'd1000) >> 17;
         angle_sq = (angle * angle) >> 31;
         term     = Q31_ONE;
         sum      = longint'(Q31_ONE);
         for (int n = 1; n <= 10; n++) begin
            term = ((term * angle_sq) >> 31) / 64'((2 * n - 1) * (2 * n));
            sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
         end
         return (sum < 0) ? 64'd0 : 64'(sum);
      endfunction

      // floor(127.5 * (1 - cos(2*pi*k/1000)))
      function logic [CHAN_W-1:0] breath_level(int unsigned k);
         int unsigned folded;
         logic [63:0] c;
         logic [63:0] lift;
         logic [63:0] level;
         folded = (k > 500) ? 1000 - k : k;
         if (folded > 250) begin
            lift = Q31_ONE + cosine_q31(500 - folded);
         end else begin
            c    = cosine_q31(folded);
            lift = (c > Q31_ONE) ? 64'd0 : Q31_ONE - c;
         end
         level = (lift * 64'd255) >> 32;
         return (level > 64'd255) ? 8'hFF : level[CHAN_W-1:0];
      endfunction

      function logic [COLOR_W-1:0] scale_color(logic [COLOR_W-1:0] c, logic [CHAN_W-1:0] f);
         logic [15:0] r;
         logic [15:0] g;
         logic [15:0] b;
         r = c[23:16] * f;
         g = c[15:8] * f;
         b = c[7:0] * f;
         return {r[15:8], g[15:8], b[15:8]};
      endfunction

      function pixel_word_type advance_tick(logic [ELAPSED_W-1:0] elapsed);
         logic [PHASE_W-1:0] t;
         int unsigned        period;
         int unsigned        k;
         pixel_word_type     w;
         phase_ms = phase_ms + PHASE_W'(elapsed);
         t        = phase_ms;
         w        = '0;
         case (pattern) inside
            PAT_SOLID: w.color = base_color;
            PAT_PULSE_SLOW, PAT_PULSE_FAST: begin
               period  = (pattern == PAT_PULSE_SLOW) ? 1000 : 250;
               k       = (t % period) * 1000 / period;
               w.color = scale_color(base_color, breath_level(k % 1000));
            end
            PAT_BLINK_ONCE: begin
               if (t >= 200) w.ended = 1;
               else w.color = base_color;
            end
            PAT_BLINK_DOUBLE: begin
               if (t >= 400) w.ended = 1;
               else if (t < 100 || (t >= 200 && t < 300)) w.color = base_color;
            end
            PAT_BLINK_TRIPLE: begin
               if (t >= 480) w.ended = 1;
               else if (t < 80 || (t >= 160 && t < 240) || (t >= 320 && t < 400))
                  w.color = base_color;
            end
            PAT_BLINK_SLOW: begin
               if (t % 2000 < 100) w.color = base_color;
            end
            default: ;
         endcase
         // a finished blink timeline falls back to off
         if (w.ended) pattern = PAT_OFF;
         return w;
      endfunction

      function void note_request(logic [ACTION_W-1:0] action, logic [ELAPSED_W-1:0] elapsed,
                                 logic [PATTERN_W-1:0] code, logic [COLOR_W-1:0] color);
         case (action)
            ACT_START: begin
               pattern    = code;
               base_color = color;
               phase_ms   = '0;
            end
            ACT_STOP: begin
               pattern = PAT_OFF;
               expected_pixels.push_back('0);
            end
            ACT_TICK: expected_pixels.push_back(advance_tick(elapsed));
            default: ;
         endcase
      endfunction

      function void report(string what, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
         errors++;
         $display("%0t: %s mismatch: expected %06h, got %06h", $time, what, want, got);
      endfunction

      function void check_pixel(logic [COLOR_W-1:0] color, logic ended);
         pixel_word_type want;
         if (expected_pixels.size() == 0) begin
            errors++;
            $display("%0t: result word with nothing pending: expected none, got %06h/%0b",
                     $time, color, ended);
            return;
         end
         want = expected_pixels.pop_front();
         if (color !== want.color) report("pixel_color", want.color, color);
         if (ended !== want.ended) report("pattern_ended", 24'(want.ended), 24'(ended));
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [ACTION_W-1:0]    req_tuser  = ACT_TICK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;

   led_scoreboard_type sb = new();
   int  cycle_count  = 0;
   bit  idle_on      = 1;
   int  hold_trigger = 0;
   int  hold_seen    = 0;
   int  stall_left   = 0;

   led_pattern_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #CLOCK_HALF clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("led_pattern_generator regression: fail");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (!idle_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [ELAPSED_W-1:0] pick_elapsed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 16'($urandom_range(0, 120));
      if (r < 85) return 16'($urandom_range(0, 1100));
      if (r < 95) return 16'($urandom);
      return (r < 97) ? 16'd0 : 16'hFFFF;
   endfunction

   function automatic logic [COLOR_W-1:0] pick_color();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 24'h000000;
      if (r == 1) return 24'hFFFFFF;
      return 24'($urandom);
   endfunction

   // result side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      int g;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tlast);
         if (hold_seen != hold_trigger) begin
            hold_seen  <= hold_trigger;
            stall_left <= LONG_HOLD_CYCLES - 1;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            g = pick_gap();
            rsp_tready <= (g == 0);
            stall_left <= (g > 0) ? g - 1 : 0;
         end
      end
   end

   task automatic send_word(input logic [ACTION_W-1:0] action,
                            input logic [ELAPSED_W-1:0] elapsed,
                            input logic [PATTERN_W-1:0] code,
                            input logic [COLOR_W-1:0] color);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= REQ_DATA_W'({color, code, elapsed});
      do @(posedge clock); while (!req_tready);
      sb.note_request(action, elapsed, code, color);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   initial begin
      int  sent;
      int  sel;
      bit  hold_done;
      bit  drain_done;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: every pattern, timeline edges, field extremes
      send_word(ACT_TICK, 16'd0, PAT_OFF, 24'h000000);
      send_word(ACT_START, 16'hFFFF, PAT_SOLID, 24'hFFFFFF);
      send_word(ACT_TICK, 16'hFFFF, PAT_BLINK_SLOW, 24'hFFFFFF);
      send_word(ACT_START, 16'd0, PAT_PULSE_SLOW, 24'hFFFFFF);
      send_word(ACT_TICK, 16'd500, PAT_OFF, 24'h000000);   // peak of the breath
      send_word(ACT_TICK, 16'd500, PAT_OFF, 24'h000000);   // back to zero
      send_word(ACT_START, 16'd0, PAT_PULSE_FAST, 24'h80FF01);
      send_word(ACT_TICK, 16'd62, PAT_OFF, 24'h000000);
      send_word(ACT_START, 16'd0, PAT_BLINK_ONCE, 24'h123456);
      send_word(ACT_TICK, 16'd199, PAT_OFF, 24'h000000);
      send_word(ACT_TICK, 16'd1, PAT_OFF, 24'h000000);     // blink ends at 200
      send_word(ACT_START, 16'd0, PAT_BLINK_DOUBLE, 24'hABCDEF);
      send_word(ACT_TICK, 16'd250, PAT_OFF, 24'h000000);
      send_word(ACT_TICK, 16'd150, PAT_OFF, 24'h000000);   // ends at 400
      send_word(ACT_START, 16'd0, PAT_BLINK_TRIPLE, 24'hFFFFFF);
      send_word(ACT_TICK, 16'd79, PAT_OFF, 24'h000000);
      send_word(ACT_TICK, 16'd401, PAT_OFF, 24'h000000);   // ends at 480
      send_word(ACT_START, 16'd0, PAT_BLINK_SLOW, 24'h00FF00);
      send_word(ACT_TICK, 16'd99, PAT_OFF, 24'h000000);
      send_word(ACT_TICK, 16'd1901, PAT_OFF, 24'h000000);  // next flash at 2000
      send_word(ACT_STOP, 16'hFFFF, PAT_BLINK_SLOW, 24'hFFFFFF);
      send_word(ACT_UNUSED, 16'hFFFF, PAT_BLINK_SLOW, 24'hFFFFFF);
      send_word(ACT_START, 16'd0, PAT_OFF, 24'hFFFFFF);
      send_word(ACT_TICK, 16'hFFFF, PAT_OFF, 24'h000000);

      // full-rate run of large steps while breathing
      idle_on = 0;
      send_word(ACT_START, 16'($urandom), PAT_PULSE_SLOW, pick_color());
      repeat (FULL_RATE_ITEMS)
         send_word(ACT_TICK, 16'($urandom_range(65000, 65535)), 3'($urandom), 24'($urandom));
      repeat (20) send_word(ACT_TICK, pick_elapsed(), 3'($urandom), 24'($urandom));
      send_word(ACT_STOP, 16'($urandom), 3'($urandom), 24'($urandom));
      send_word(ACT_TICK, pick_elapsed(), 3'($urandom), 24'($urandom));
      idle_on = 1;

      // random pattern sequences with some stops and unused-action noise
      sent       = 0;
      hold_done  = 0;
      drain_done = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 150 && !hold_done) begin
            hold_trigger = hold_trigger + 1;
            hold_done    = 1;
         end
         if (sent >= 350 && !drain_done) begin
            wait_for_results();
            drain_done = 1;
         end
         idle_on = ($urandom_range(0, 9) != 0);
         sel     = $urandom_range(0, 99);
         if (sel < 5) begin
            send_word(ACT_UNUSED, 16'($urandom), 3'($urandom), 24'($urandom));
         end else if (sel < 12) begin
            send_word(ACT_STOP, 16'($urandom), 3'($urandom), 24'($urandom));
            sent++;
         end else begin
            send_word(ACT_START, 16'($urandom), 3'($urandom_range(0, 7)), pick_color());
            sent++;
            repeat ($urandom_range(1, 16)) begin
               send_word(ACT_TICK, pick_elapsed(), 3'($urandom), 24'($urandom));
               sent++;
            end
         end
      end
      idle_on = 1;

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("led_pattern_generator regression: pass");
      end else begin
         $display("led_pattern_generator regression: fail");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/lpg_pkg.sv
hw/rtl/led_pattern_generator.sv
tb/sv/testbench.sv
